// ===== sv/cht_pkg.sv =====
// Shared types and codes for the chained hash table engine.
package cht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_DUP     = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] key;
  } kv_t;

  typedef struct packed {
    logic [31:0] found_value;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic row_rd;
    logic row_wr;
    logic kv_rd;
    logic kv_wr;
  } store_ctl_t;

endpackage

// ===== sv/chained_hash_table_engine.sv =====
// Each item passes through the 4 hash stages, one valid-row read, one key read per
// scanned way and a write-back step, from input accept to result valid.
// s_axis_tready stays low until the current item is finished; the key scan reads one slot
// per cycle from the single-port key/value memory. A waiting result does not block the next accept.
// Reset: a clearing pass zeroes the valid rows; s_axis_tready is low
// during it. Key/value memory is not cleared.
module chained_hash_table_engine #(
  parameter int BUCKETS = 32,
  parameter int WAYS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // op[1:0], key[33:2], value[65:34], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], found_value[33:2], zero pad
);
  import cht_pkg::*;

  localparam int BucketAw = $clog2(BUCKETS);
  localparam int SlotAw   = $clog2(BUCKETS * WAYS);
  localparam int WayW     = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [31:0]         key_q, key_d;
  logic [31:0]         val_q, val_d;
  logic [WayW-1:0]     cw_q, cw_d;
  logic                hit_q, hit_d;
  logic [WayW-1:0]     hit_way_q, hit_way_d;
  logic [31:0]         hit_val_q, hit_val_d;
  logic                m_valid_q, m_valid_d;
  result_t             res_q, res_d;

  logic                hash_start;
  logic                hash_done;
  logic [BucketAw-1:0] bucket;
  logic [SlotAw-1:0]   base;

  store_ctl_t          ctl;
  logic [WAYS-1:0]     row_wdata;
  logic [WAYS-1:0]     row_rdata;
  logic [SlotAw-1:0]   kv_addr;
  kv_t                 kv_wdata;
  kv_t                 kv_rdata;
  logic                busy;

  logic                accept;
  logic                out_free;
  logic                hit_now;
  logic [WayW-1:0]     free_way;
  logic                full;

  cht_hash #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (s_axis_tdata[33:2]),
    .done_o  (hash_done),
    .bucket_o(bucket),
    .base_o  (base)
  );

  cht_store #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .row_addr_i (bucket),
    .row_wdata_i(row_wdata),
    .row_rdata_o(row_rdata),
    .kv_addr_i  (kv_addr),
    .kv_wdata_i (kv_wdata),
    .kv_rdata_o (kv_rdata),
    .busy_o     (busy)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign hit_now       = row_rdata[cw_q] && (kv_rdata.key == key_q);
  assign full          = &row_rdata;
  assign kv_wdata      = '{value: val_q, key: key_q};

  // Lowest free way of the bucket.
  always_comb begin
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_rdata[i]) begin
        free_way = WayW'(i);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    cw_d       = cw_q;
    hit_d      = hit_q;
    hit_way_d  = hit_way_q;
    hit_val_d  = hit_val_q;
    res_d      = res_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    hash_start = 1'b0;
    ctl        = '0;
    row_wdata  = row_rdata;
    kv_addr    = base + SlotAw'(cw_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = s_axis_tdata[1:0];
          key_d      = s_axis_tdata[33:2];
          val_d      = s_axis_tdata[65:34];
          hash_start = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          ctl.row_rd = 1'b1;
          state_d    = S_ROW;
        end
      end
      S_ROW: begin
        ctl.kv_rd = 1'b1;
        kv_addr   = base;
        cw_d      = '0;
        hit_d     = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (hit_now) begin
          hit_d     = 1'b1;
          hit_way_d = cw_q;
          hit_val_d = kv_rdata.value;
          state_d   = S_FIN;
        end else if (cw_q == WayW'(WAYS - 1)) begin
          state_d = S_FIN;
        end else begin
          cw_d      = cw_q + WayW'(1);
          ctl.kv_rd = 1'b1;
          kv_addr   = base + SlotAw'(cw_q) + SlotAw'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d         = 1'b1;
          state_d           = S_IDLE;
          res_d.found_value = '0;
          res_d.status      = STATUS_MISSING;
          case (op_q)
            OP_INSERT: begin
              if (hit_q) begin
                res_d.status = STATUS_DUP;
              end else if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                ctl.row_wr   = 1'b1;
                row_wdata    = row_rdata | (WAYS'(1) << free_way);
                ctl.kv_wr    = 1'b1;
                kv_addr      = base + SlotAw'(free_way);
                res_d.status = STATUS_DONE;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                ctl.row_wr   = 1'b1;
                row_wdata    = row_rdata & ~(WAYS'(1) << hit_way_q);
                res_d.status = STATUS_DONE;
              end
            end
            OP_LOOKUP: begin
              if (hit_q) begin
                res_d.status      = STATUS_DONE;
                res_d.found_value = hit_val_q;
              end
            end
            default: begin
              res_d.status = STATUS_MISSING;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    val_q     <= val_d;
    cw_q      <= cw_d;
    hit_q     <= hit_d;
    hit_way_q <= hit_way_d;
    hit_val_q <= hit_val_d;
    res_q     <= res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

endmodule

// ===== sv/cht_hash.sv =====
// Pipelined bucket hash: (2*key*key mod 2^32) mod BUCKETS, plus the bucket's first slot.
module cht_hash #(
  parameter int BUCKETS = 32,
  parameter int WAYS = 8,
  localparam int BucketAw = $clog2(BUCKETS),
  localparam int SlotAw = $clog2(BUCKETS * WAYS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         key_i,
  output logic                done_o,
  output logic [BucketAw-1:0] bucket_o,
  output logic [SlotAw-1:0]   base_o
);

  // Reciprocal of BUCKETS, exact for every 32-bit dividend.
  localparam int Shift = 32 + BucketAw;
  localparam logic [64:0] MagicWide =
    ((65'd1 << Shift) + 65'(BUCKETS) - 65'd1) / 65'(BUCKETS);
  localparam logic [32:0] Magic = MagicWide[32:0];

  logic [3:0]          v_q;
  logic [31:0]         sq_q;
  logic [31:0]         h2_q;
  logic [64:0]         prod_q;
  logic [31:0]         h3_q;
  logic [31:0]         qb_q;
  logic [BucketAw-1:0] bucket_q;
  logic [SlotAw-1:0]   base_q;

  logic [31:0]         h;
  logic [31:0]         quot;
  logic [31:0]         rem;

  assign h    = {sq_q[30:0], 1'b0};
  assign quot = 32'(prod_q >> Shift);
  assign rem  = h3_q - qb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sq_q <= key_i * key_i;
    end
    if (v_q[0]) begin
      h2_q   <= h;
      prod_q <= 65'(h) * 65'(Magic);
    end
    if (v_q[1]) begin
      h3_q <= h2_q;
      qb_q <= quot * 32'(BUCKETS);
    end
    if (v_q[2]) begin
      bucket_q <= rem[BucketAw-1:0];
      base_q   <= SlotAw'(rem[BucketAw-1:0]) * SlotAw'(WAYS);
    end
  end

  assign done_o   = v_q[3];
  assign bucket_o = bucket_q;
  assign base_o   = base_q;

endmodule

// ===== sv/cht_store.sv =====
// Bucket valid rows and slot key/value memory, with the clearing pass after reset.
module cht_store #(
  parameter int BUCKETS = 32,
  parameter int WAYS = 8,
  localparam int BucketAw = $clog2(BUCKETS),
  localparam int SlotAw = $clog2(BUCKETS * WAYS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cht_pkg::store_ctl_t ctl_i,
  input  logic [BucketAw-1:0] row_addr_i,
  input  logic [WAYS-1:0]     row_wdata_i,
  output logic [WAYS-1:0]     row_rdata_o,
  input  logic [SlotAw-1:0]   kv_addr_i,
  input  cht_pkg::kv_t        kv_wdata_i,
  output cht_pkg::kv_t        kv_rdata_o,
  output logic                busy_o
);
  import cht_pkg::*;

  logic [WAYS-1:0]     row_mem [BUCKETS];
  kv_t                 kv_mem [BUCKETS * WAYS];

  logic [WAYS-1:0]     row_rdata_q;
  kv_t                 kv_rdata_q;
  logic                clr_q, clr_d;
  logic [BucketAw-1:0] clr_cnt_q, clr_cnt_d;

  logic                row_we;
  logic [BucketAw-1:0] row_waddr;
  logic [WAYS-1:0]     row_wdata;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + BucketAw'(1);
      if (clr_cnt_q == BucketAw'(BUCKETS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  assign row_we    = clr_q || ctl_i.row_wr;
  assign row_waddr = clr_q ? clr_cnt_q : row_addr_i;
  assign row_wdata = clr_q ? '0 : row_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (ctl_i.row_rd) begin
      row_rdata_q <= row_mem[row_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.kv_wr) begin
      kv_mem[kv_addr_i] <= kv_wdata_i;
    end
    if (ctl_i.kv_rd) begin
      kv_rdata_q <= kv_mem[kv_addr_i];
    end
  end

  assign row_rdata_o = row_rdata_q;
  assign kv_rdata_o  = kv_rdata_q;
  assign busy_o      = clr_q;

endmodule

// ===== sv/cht_checker.sv =====
// Port-level checks for the chained hash table engine, bound to the top level.
module cht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import cht_pkg::*;

  // A nonzero value is only returned by a successful lookup.
  a_value_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:2] != 32'd0) |-> m_axis_tdata[1:0] == STATUS_DONE)
    else $error("nonzero found_value with non-done status");

  // One item in flight: ready drops right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  // Clearing pass keeps the input closed on the first cycle out of reset.
  a_clear_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (.*);

// ===== bench/chained_hash_table_engine_tb.sv =====
// Self-checking bench for the chained hash table engine: directed table, then random traffic.
module chained_hash_table_engine_tb;
  import cht_pkg::*;

  localparam int BUCKETS = 32;
  localparam int WAYS = 8;
  localparam int RANDOM_OPS = 1300;
  localparam int KEY_POOL = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic        typed;  // use want below instead of the shadow store
    result_t     want;   // found_value, status
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // op[1:0], key[33:2], value[65:34], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // status[1:0], found_value[33:2], zero pad

  // shadow copy of the slot store
  logic        shadow_valid [BUCKETS*WAYS];
  logic [31:0] shadow_key   [BUCKETS*WAYS];
  logic [31:0] shadow_value [BUCKETS*WAYS];

  result_t     results_due[$];
  logic [31:0] key_pool [KEY_POOL];
  int          mismatches = 0;
  int          burst_left = 0;

  logic [31:0] rdy_pattern = '0;
  int          rdy_left = 0;
  int          rdy_pos = 0;
  logic        rdy_free = 1'b0;

  // only keys with 2*k*k mod 32 in {0, 2, 8, 18} exist, so buckets fill up quickly
  op_row_t directed_rows [0:23] = '{
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, STATUS_MISSING}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, STATUS_MISSING}},
    '{OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0, STATUS_DONE}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STATUS_DONE}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, STATUS_DONE}},
    '{OP_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1, '{32'h0, STATUS_DUP}},
    '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, STATUS_DONE}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, STATUS_MISSING}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, STATUS_MISSING}},
    // multiples of 4 all land in bucket 0: fill it
    '{OP_INSERT, 32'd4,  32'h0000_0104, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd8,  32'h0000_0108, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd12, 32'hFFFF_FF12, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd16, 32'h0000_0116, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd20, 32'h8000_0020, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd24, 32'h0000_0124, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd28, 32'h0000_0128, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd32, 32'h0000_0132, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd36, 32'h0000_0136, 1'b1, '{32'h0, STATUS_FULL}},
    // present key in a full bucket is a duplicate, not full
    '{OP_INSERT, 32'd4,  32'h0000_0999, 1'b1, '{32'h0, STATUS_DUP}},
    '{OP_REMOVE, 32'd16, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_INSERT, 32'd36, 32'h0000_0136, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_LOOKUP, 32'd36, 32'h0000_0000, 1'b0, '{32'h0, STATUS_DONE}},
    '{OP_LOOKUP, 32'd16, 32'h0000_0000, 1'b1, '{32'h0, STATUS_MISSING}}
  };

  chained_hash_table_engine #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Applies one op to the shadow store and returns what the engine should answer.
  function automatic result_t hash_store_apply(logic [1:0] op, logic [31:0] key,
                                               logic [31:0] value);
    result_t     res;
    logic [31:0] sq;
    int          base;
    int          hit;
    sq = key * key;
    sq = sq * 32'd2;
    base = int'(sq % 32'(BUCKETS)) * WAYS;
    hit = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (hit < 0 && shadow_valid[base+w] && shadow_key[base+w] == key) hit = base + w;
    end
    res.status = STATUS_MISSING;
    res.found_value = '0;
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = STATUS_DUP;
        end else begin
          res.status = STATUS_FULL;
          for (int w = 0; w < WAYS; w++) begin
            if (res.status == STATUS_FULL && !shadow_valid[base+w]) begin
              shadow_valid[base+w] = 1'b1;
              shadow_key[base+w] = key;
              shadow_value[base+w] = value;
              res.status = STATUS_DONE;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          res.status = STATUS_DONE;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          res.status = STATUS_DONE;
          res.found_value = shadow_value[hit];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_op(logic [1:0] op, logic [31:0] key, logic [31:0] value,
                         logic typed, result_t want);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, value, key, op};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    predicted = hash_store_apply(op, key, value);
    results_due.push_back(typed ? want : predicted);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Receiver: works in windows, each either always ready or stalling on a random pattern.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rdy_left == 0) begin
        rdy_free = ($urandom_range(0, 3) == 0);
        rdy_pattern = $urandom() | $urandom();
        rdy_left = 64;
        rdy_pos = 0;
      end
      m_axis_tready <= rdy_free | rdy_pattern[rdy_pos % 32];
      rdy_pos++;
      rdy_left--;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due", '0, got.found_value);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.found_value !== want.found_value)
          report_mismatch("found_value", want.found_value, got.found_value);
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] key;
    int          pick;
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].want);
    end

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) begin
        // drain fully before resuming
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (results_due.size() != 0) @(negedge clk_i);
        burst_left = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_UNUSED;
      else if (pick < 47) op = OP_INSERT;
      else if (pick < 70) op = OP_REMOVE;
      else op = OP_LOOKUP;
      key = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, KEY_POOL-1)];
      send_op(op, key, $urandom(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (WAYS + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
